[design/cbd_pkg.sv]
// shared constants, codes and types of the cell balance duty controller
package cbd_pkg;

	// default geometry of the pack
	localparam int NUM_MODULES_DEF      = 8;
	localparam int CELLS_PER_MODULE_DEF = 16;

	// voltage store
	localparam int STORE_DEPTH = 128;
	localparam int CELL_ADDR_W = 7;
	localparam int VOLT_W      = 16;
	localparam int LIMIT_W     = VOLT_W + 1;

	// millisecond counters and timing registers
	localparam int          MS_W   = 24;
	localparam logic [23:0] MS_MAX = 24'hFFFFFF;

	// field widths
	localparam int MODE_W         = 2;
	localparam int CMD_W          = 8;
	localparam int STATE_W        = 2;
	localparam int MODULE_INDEX_W = 3;
	localparam int CELL_MASK_W    = 16;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// command byte codes
	localparam logic [CMD_W-1:0] CMD_DISABLE = 8'd0;
	localparam logic [CMD_W-1:0] CMD_ENABLE  = 8'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK    = 2'd0,
		MODE_COMMAND = 2'd1,
		MODE_VOLT_WR = 2'd2,
		MODE_MIN_WR  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT   = 2'd0,
		CFG_REST      = 2'd1,
		CFG_ACTIVE    = 2'd2,
		CFG_THRESHOLD = 2'd3
	} cfg_reg_t;

	typedef enum logic [STATE_W-1:0] {
		BAL_DISABLED = 2'd0,
		BAL_REST     = 2'd1,
		BAL_ACTIVE   = 2'd2
	} bal_state_t;

	// one finished module mask from the walker
	typedef struct packed {
		logic                      ready;
		logic                      last;
		logic [MODULE_INDEX_W-1:0] module_idx;
		logic [CELL_MASK_W-1:0]    mask;
	} mask_res_t;

endpackage

[design/cbd_cell_store.sv]
// cell voltage memory with per-entry valid bits, unwritten entries read as zero
module cbd_cell_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [cbd_pkg::CELL_ADDR_W-1:0] wr_addr,
	input  logic [cbd_pkg::VOLT_W-1:0]  wr_data,
	input  logic [cbd_pkg::CELL_ADDR_W-1:0] rd_addr,
	output logic [cbd_pkg::VOLT_W-1:0]  rd_data
);
	import cbd_pkg::*;

	logic [VOLT_W-1:0]      mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;
	logic [VOLT_W-1:0]      rd_data_q;
	logic                   rd_vld_q;

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

[design/cbd_mask_walk.sv]
// mask walker: one shared compare unit steps through the cells of each module
module cbd_mask_walk #(
	parameter int NUM_MODULES      = cbd_pkg::NUM_MODULES_DEF,
	parameter int CELLS_PER_MODULE = cbd_pkg::CELLS_PER_MODULE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            select,
	input  logic [cbd_pkg::LIMIT_W-1:0]     limit,
	input  logic                            consume,
	output logic [cbd_pkg::CELL_ADDR_W-1:0] rd_addr,
	input  logic [cbd_pkg::VOLT_W-1:0]      rd_data,
	output cbd_pkg::mask_res_t              res
);
	import cbd_pkg::*;

	localparam int MOD_W  = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
	localparam int CELL_W = (CELLS_PER_MODULE > 1) ? $clog2(CELLS_PER_MODULE) : 1;
	localparam int ADDR_W = $clog2(NUM_MODULES * CELLS_PER_MODULE + 1);

	typedef enum logic [1:0] {
		W_IDLE,
		W_RUN,
		W_DRAIN,
		W_HOLD
	} walk_state_t;

	walk_state_t                 st_q;
	logic [MOD_W-1:0]            mod_q;
	logic [CELL_W-1:0]           cell_q;
	logic [ADDR_W-1:0]           addr_q;
	logic [CELLS_PER_MODULE-1:0] mask_q;
	logic                        sel_q;
	logic [LIMIT_W-1:0]          limit_q;
	logic                        issue_s1;
	logic [CELL_W-1:0]           cell_s1;
	logic                        inrange_s1;
	logic                        hit;
	logic                        addr_inrange;

	assign rd_addr      = CELL_ADDR_W'(addr_q);
	assign addr_inrange = {{(32-ADDR_W){1'b0}}, addr_q} < 32'(STORE_DEPTH);

	// shared compare on the registered read data
	assign hit = issue_s1 && sel_q && inrange_s1 && ({1'b0, rd_data} > limit_q);

	// sequencer over modules and cells, with the compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= W_IDLE;
			mod_q      <= '0;
			cell_q     <= '0;
			addr_q     <= '0;
			mask_q     <= '0;
			sel_q      <= 1'b0;
			limit_q    <= '0;
			issue_s1   <= 1'b0;
			cell_s1    <= '0;
			inrange_s1 <= 1'b0;
		end else begin
			issue_s1   <= (st_q == W_RUN);
			cell_s1    <= cell_q;
			inrange_s1 <= addr_inrange;
			if (hit) begin
				mask_q[cell_s1] <= 1'b1;
			end
			unique case (st_q)
				W_IDLE: begin
					if (start) begin
						mod_q   <= '0;
						cell_q  <= '0;
						addr_q  <= '0;
						mask_q  <= '0;
						sel_q   <= select;
						limit_q <= limit;
						st_q    <= W_RUN;
					end
				end
				W_RUN: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (cell_q == CELL_W'(CELLS_PER_MODULE - 1)) begin
						cell_q <= '0;
						st_q   <= W_DRAIN;
					end else begin
						cell_q <= cell_q + CELL_W'(1);
					end
				end
				W_DRAIN: begin
					st_q <= W_HOLD;
				end
				W_HOLD: begin
					if (consume) begin
						if (mod_q == MOD_W'(NUM_MODULES - 1)) begin
							st_q <= W_IDLE;
						end else begin
							mod_q  <= mod_q + MOD_W'(1);
							mask_q <= '0;
							st_q   <= W_RUN;
						end
					end
				end
				default: st_q <= W_IDLE;
			endcase
		end
	end

	// finished mask toward the output stage
	always_comb begin
		res            = '0;
		res.ready      = (st_q == W_HOLD);
		res.last       = (mod_q == MOD_W'(NUM_MODULES - 1));
		res.module_idx = MODULE_INDEX_W'(mod_q);
		res.mask       = CELL_MASK_W'(mask_q);
	end

endmodule

[design/cell_balance_duty_controller.sv]
// top level of the passive cell balance duty controller
// a command, voltage write, minimum write or tick with no state entry: accepted in idle,
// then its single result is registered in the result state once the output slot is free
// a tick that enters a state: the walker reads one stored cell voltage per cycle of a module
// through the single compare unit, and waits in hold until each finished mask is taken
// asynchronous active-low reset: disabled state, zeroed counters, empty voltage store
module cell_balance_duty_controller #(
	parameter int NUM_MODULES      = cbd_pkg::NUM_MODULES_DEF,
	parameter int CELLS_PER_MODULE = cbd_pkg::CELLS_PER_MODULE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_we,
	input  logic [cbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cbd_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [cbd_pkg::MODE_W-1:0]         mode,
	input  logic [cbd_pkg::CMD_W-1:0]          command_value,
	input  logic [cbd_pkg::CELL_ADDR_W-1:0]    cell_index,
	input  logic [cbd_pkg::VOLT_W-1:0]         voltage_mv,
	input  logic                               fault,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [cbd_pkg::STATE_W-1:0]        balance_state,
	output logic                               mask_valid,
	output logic [cbd_pkg::MODULE_INDEX_W-1:0] module_index,
	output logic [cbd_pkg::CELL_MASK_W-1:0]    cell_mask,
	output logic                               last
);
	import cbd_pkg::*;

	typedef enum logic [1:0] {
		T_IDLE,
		T_RESULT,
		T_MASKS
	} top_state_t;

	top_state_t          st_q;
	bal_state_t          bal_q;
	bal_state_t          prev_q;
	logic [MS_W-1:0]     since_q;
	logic [MS_W-1:0]     tis_q;
	logic [VOLT_W-1:0]   pack_min_q;

	logic [MS_W-1:0]     timeout_q;
	logic [MS_W-1:0]     rest_len_q;
	logic [MS_W-1:0]     active_len_q;
	logic [VOLT_W-1:0]   threshold_q;

	logic                out_valid_q;
	logic [STATE_W-1:0]  out_state_q;
	logic                out_mvalid_q;
	logic [MODULE_INDEX_W-1:0] out_mod_q;
	logic [CELL_MASK_W-1:0]    out_mask_q;
	logic                out_last_q;

	bal_state_t          bal_n;
	bal_state_t          prev_n;
	logic [MS_W-1:0]     since_n;
	logic [MS_W-1:0]     tis_n;
	logic                emit_n;
	logic                sel_n;

	logic                accept;
	logic                slot_free;
	logic                out_load;
	logic                walk_start;
	logic                consume;
	logic                store_we;
	logic [LIMIT_W-1:0]  limit;
	logic [CELL_ADDR_W-1:0] rd_addr;
	logic [VOLT_W-1:0]   rd_data;
	mask_res_t           res;

	assign in_stall  = (st_q != T_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign store_we  = accept && (mode_t'(mode) == MODE_VOLT_WR);
	assign walk_start = accept && (mode_t'(mode) == MODE_TICK) && emit_n;
	assign consume   = (st_q == T_MASKS) && res.ready && slot_free;
	assign out_load  = ((st_q == T_RESULT) && slot_free) || consume;
	assign limit     = {1'b0, pack_min_q} + {1'b0, threshold_q};

	// next balancing state for a command or a tick
	always_comb begin
		logic [MS_W-1:0] since_inc;
		logic [MS_W-1:0] tis_inc;
		bal_state_t      st;
		since_inc = (since_q == MS_MAX) ? since_q : since_q + MS_W'(1);
		tis_inc   = (tis_q == MS_MAX) ? tis_q : tis_q + MS_W'(1);
		st        = bal_q;
		bal_n     = bal_q;
		prev_n    = prev_q;
		since_n   = since_q;
		tis_n     = tis_q;
		emit_n    = 1'b0;
		sel_n     = 1'b0;
		unique case (mode_t'(mode))
			MODE_COMMAND: begin
				since_n = '0;
				if (command_value == CMD_ENABLE && bal_q == BAL_DISABLED && !fault) begin
					bal_n = BAL_ACTIVE;
					tis_n = '0;
				end else if (command_value == CMD_DISABLE) begin
					bal_n = BAL_DISABLED;
					tis_n = '0;
				end
			end
			MODE_TICK: begin
				since_n = since_inc;
				tis_n   = tis_inc;
				// command timeout, then fault override
				if (st != BAL_DISABLED && since_inc > timeout_q) begin
					st = BAL_DISABLED;
				end
				if (fault) begin
					st = BAL_DISABLED;
				end
				// entry and duration rules
				unique case (st)
					BAL_REST: begin
						if (prev_q != BAL_REST) begin
							tis_n  = '0;
							emit_n = 1'b1;
							prev_n = BAL_REST;
						end
						bal_n = (tis_n >= rest_len_q) ? BAL_ACTIVE : BAL_REST;
					end
					BAL_ACTIVE: begin
						if (prev_q != BAL_ACTIVE) begin
							tis_n  = '0;
							emit_n = 1'b1;
							sel_n  = 1'b1;
							prev_n = BAL_ACTIVE;
						end
						bal_n = (tis_n >= active_len_q) ? BAL_REST : BAL_ACTIVE;
					end
					default: begin
						bal_n = BAL_DISABLED;
						if (prev_q != BAL_DISABLED) begin
							emit_n = 1'b1;
							prev_n = BAL_DISABLED;
						end
					end
				endcase
			end
			MODE_VOLT_WR, MODE_MIN_WR: begin
				bal_n = bal_q;
			end
			default: bal_n = bal_q;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= MS_W'(1000);
			rest_len_q   <= MS_W'(10000);
			active_len_q <= MS_W'(30000);
			threshold_q  <= VOLT_W'(10);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_TIMEOUT:   timeout_q    <= cfg_data;
				CFG_REST:      rest_len_q   <= cfg_data;
				CFG_ACTIVE:    active_len_q <= cfg_data;
				CFG_THRESHOLD: threshold_q  <= cfg_data[VOLT_W-1:0];
				default:       timeout_q    <= timeout_q;
			endcase
		end
	end

	// item sequencer, balancing state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= T_IDLE;
			bal_q        <= BAL_DISABLED;
			prev_q       <= BAL_DISABLED;
			since_q      <= '0;
			tis_q        <= '0;
			pack_min_q   <= '0;
			out_valid_q  <= 1'b0;
			out_state_q  <= '0;
			out_mvalid_q <= 1'b0;
			out_mod_q    <= '0;
			out_mask_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// result slot: filled on a load, emptied when taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				T_IDLE: begin
					if (accept) begin
						bal_q   <= bal_n;
						prev_q  <= prev_n;
						since_q <= since_n;
						tis_q   <= tis_n;
						if (mode_t'(mode) == MODE_MIN_WR) begin
							pack_min_q <= voltage_mv;
						end
						st_q <= walk_start ? T_MASKS : T_RESULT;
					end
				end
				T_RESULT: begin
					if (slot_free) begin
						out_state_q  <= bal_q;
						out_mvalid_q <= 1'b0;
						out_mod_q    <= '0;
						out_mask_q   <= '0;
						out_last_q   <= 1'b1;
						st_q         <= T_IDLE;
					end
				end
				T_MASKS: begin
					if (consume) begin
						out_state_q  <= bal_q;
						out_mvalid_q <= 1'b1;
						out_mod_q    <= res.module_idx;
						out_mask_q   <= res.mask;
						out_last_q   <= res.last;
						if (res.last) begin
							st_q <= T_IDLE;
						end
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign balance_state = out_state_q;
	assign mask_valid    = out_mvalid_q;
	assign module_index  = out_mod_q;
	assign cell_mask     = out_mask_q;
	assign last          = out_last_q;

	cbd_cell_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (store_we),
		.wr_addr (cell_index),
		.wr_data (voltage_mv),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cbd_mask_walk #(
		.NUM_MODULES      (NUM_MODULES),
		.CELLS_PER_MODULE (CELLS_PER_MODULE)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (walk_start),
		.select  (sel_n),
		.limit   (limit),
		.consume (consume),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.res     (res)
	);

endmodule

[design/cbd_checker.sv]
// port-level checks of the cell balance duty controller, bound to the top level
module cbd_port_checks (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [cbd_pkg::STATE_W-1:0]        balance_state,
	input logic                               mask_valid,
	input logic [cbd_pkg::MODULE_INDEX_W-1:0] module_index,
	input logic [cbd_pkg::CELL_MASK_W-1:0]    cell_mask,
	input logic                               last
);
	import cbd_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a transaction without a mask is a single, empty, final result
	a_plain_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mask_valid |-> last && cell_mask == '0 && module_index == '0)
		else $error("result without mask carries mask data");

	// masks that end in disabled never select a cell
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mask_valid && balance_state == BAL_DISABLED |-> cell_mask == '0)
		else $error("nonzero mask emitted on entry to disabled");

	// the block is busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken before the first finished");

endmodule

bind cell_balance_duty_controller cbd_port_checks u_cbd_port_checks (.*);

[dv/cbd_checker.sv]
`timescale 1ns / 1ps
// channel checker of the cell balance duty controller: predicts and compares every result
module cbd_checker
	import cbd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [MODE_W-1:0]         mode,
	input  logic [CMD_W-1:0]          command_value,
	input  logic [CELL_ADDR_W-1:0]    cell_index,
	input  logic [VOLT_W-1:0]         voltage_mv,
	input  logic                      fault,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [STATE_W-1:0]        balance_state,
	input  logic                      mask_valid,
	input  logic [MODULE_INDEX_W-1:0] module_index,
	input  logic [CELL_MASK_W-1:0]    cell_mask,
	input  logic                      last,
	input  logic                      run_done,
	output int                        fail_count,
	output int                        pending_count
);

	localparam int MODULES = NUM_MODULES_DEF;
	localparam int CELLS   = CELLS_PER_MODULE_DEF;

	typedef struct packed {
		bal_state_t                state;
		logic                      mask_valid;
		logic [MODULE_INDEX_W-1:0] module_idx;
		logic [CELL_MASK_W-1:0]    mask;
		logic                      last;
	} balance_result_t;

	// predicted copy of configuration and state
	logic [MS_W-1:0]   cmd_timeout;
	logic [MS_W-1:0]   rest_len;
	logic [MS_W-1:0]   active_len;
	logic [VOLT_W-1:0] thresh;
	bal_state_t        cur_state;
	bal_state_t        prev_state;
	logic [MS_W-1:0]   cmd_age;
	logic [MS_W-1:0]   state_age;
	logic [VOLT_W-1:0] volt_store [STORE_DEPTH];
	logic [VOLT_W-1:0] pack_min;

	balance_result_t awaited_results [$];
	bit leftovers_checked = 1'b0;

	task automatic report(input string msg);
		if (fail_count < 40)
			$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic clear_balance_model();
		cmd_timeout = 24'd1000;
		rest_len    = 24'd10000;
		active_len  = 24'd30000;
		thresh      = 16'd10;
		cur_state   = BAL_DISABLED;
		prev_state  = BAL_DISABLED;
		cmd_age     = '0;
		state_age   = '0;
		pack_min    = '0;
		for (int i = 0; i < STORE_DEPTH; i++)
			volt_store[i] = '0;
		awaited_results.delete();
	endtask

	// cells strictly above minimum plus threshold, compared one bit wider so nothing wraps
	function automatic logic [CELL_MASK_W-1:0] discharge_mask(input int m);
		logic [CELL_MASK_W-1:0] sel;
		logic [LIMIT_W-1:0]     limit;
		sel = '0;
		limit = {1'b0, pack_min} + {1'b0, thresh};
		for (int c = 0; c < CELLS; c++)
			if ({1'b0, volt_store[m * CELLS + c]} > limit)
				sel[c] = 1'b1;
		return sel;
	endfunction

	// one accepted input transaction: update the state copy and queue what it produces
	task automatic predict_balance_step(input mode_t md, input logic [CMD_W-1:0] cmd,
			input logic [CELL_ADDR_W-1:0] idx, input logic [VOLT_W-1:0] volt,
			input logic flt);
		logic            entered;
		logic            select;
		balance_result_t res;
		entered = 1'b0;
		select  = 1'b0;
		case (md)
			MODE_COMMAND: begin
				cmd_age = '0;
				if (cmd == CMD_ENABLE && cur_state == BAL_DISABLED && !flt) begin
					cur_state = BAL_ACTIVE;
					state_age = '0;
				end else if (cmd == CMD_DISABLE) begin
					cur_state = BAL_DISABLED;
					state_age = '0;
				end
			end
			MODE_VOLT_WR: volt_store[idx] = volt;
			MODE_MIN_WR: pack_min = volt;
			default: begin
				// millisecond tick: saturating counters, timeout, fault, then state rules
				if (cmd_age != MS_MAX)
					cmd_age = cmd_age + 1'b1;
				if (state_age != MS_MAX)
					state_age = state_age + 1'b1;
				if (cur_state != BAL_DISABLED && cmd_age > cmd_timeout)
					cur_state = BAL_DISABLED;
				if (flt)
					cur_state = BAL_DISABLED;
				case (cur_state)
					BAL_REST: begin
						if (prev_state != BAL_REST) begin
							state_age  = '0;
							entered    = 1'b1;
							prev_state = BAL_REST;
						end
						if (state_age >= rest_len)
							cur_state = BAL_ACTIVE;
					end
					BAL_ACTIVE: begin
						if (prev_state != BAL_ACTIVE) begin
							state_age  = '0;
							entered    = 1'b1;
							select     = 1'b1;
							prev_state = BAL_ACTIVE;
						end
						if (state_age >= active_len)
							cur_state = BAL_REST;
					end
					default: begin
						cur_state = BAL_DISABLED;
						if (prev_state != BAL_DISABLED) begin
							entered    = 1'b1;
							prev_state = BAL_DISABLED;
						end
					end
				endcase
			end
		endcase

		if (!entered) begin
			res = '{state: cur_state, mask_valid: 1'b0, module_idx: '0, mask: '0, last: 1'b1};
			awaited_results.push_back(res);
		end else begin
			for (int m = 0; m < MODULES; m++) begin
				res.state      = cur_state;
				res.mask_valid = 1'b1;
				res.module_idx = MODULE_INDEX_W'(m);
				res.mask       = select ? discharge_mask(m) : '0;
				res.last       = (m == MODULES - 1);
				awaited_results.push_back(res);
			end
		end
	endtask

	// compare one accepted output transaction with the oldest prediction
	task automatic check_result();
		balance_result_t want;
		if (awaited_results.size() == 0) begin
			report("output transaction with no result expected");
		end else begin
			want = awaited_results.pop_front();
			if (balance_state !== want.state || mask_valid !== want.mask_valid ||
					module_index !== want.module_idx || cell_mask !== want.mask ||
					last !== want.last)
				report($sformatf({"state %0d/%0d mask_valid %0b/%0b module %0d/%0d ",
					"mask %h/%h last %0b/%0b (got/expected)"},
					balance_state, want.state, mask_valid, want.mask_valid,
					module_index, want.module_idx, cell_mask, want.mask, last, want.last));
		end
	endtask

	// watch configuration writes and both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_balance_model();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_TIMEOUT:   cmd_timeout = cfg_data;
					CFG_REST:      rest_len    = cfg_data;
					CFG_ACTIVE:    active_len  = cfg_data;
					CFG_THRESHOLD: thresh      = cfg_data[VOLT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				predict_balance_step(mode_t'(mode), command_value, cell_index, voltage_mv, fault);
			if (run_done && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (awaited_results.size() != 0)
					report($sformatf("%0d expected results never arrived",
						awaited_results.size()));
			end
		end
		pending_count = awaited_results.size();
	end

endmodule

[dv/cell_balance_duty_controller_tb.sv]
`timescale 1ns / 1ps
// testbench top of the cell balance duty controller: stimulus, idling and verdict
module cell_balance_duty_controller_tb;
	import cbd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 400;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index     = '0;
	logic [CFG_DATA_W-1:0]     cfg_data      = '0;
	logic                      in_valid      = 1'b0;
	logic                      in_stall;
	logic [MODE_W-1:0]         mode          = '0;
	logic [CMD_W-1:0]          command_value = '0;
	logic [CELL_ADDR_W-1:0]    cell_index    = '0;
	logic [VOLT_W-1:0]         voltage_mv    = '0;
	logic                      fault         = 1'b0;
	logic                      out_valid;
	logic                      out_stall     = 1'b0;
	logic [STATE_W-1:0]        balance_state;
	logic                      mask_valid;
	logic [MODULE_INDEX_W-1:0] module_index;
	logic [CELL_MASK_W-1:0]    cell_mask;
	logic                      last;
	logic                      run_done      = 1'b0;
	int                        fail_count;
	int                        pending_count;

	// stimulus shaping
	int          items_sent   = 0;
	int          tight_items  = 0;
	bit          calm_sender  = 1'b0;
	bit          hold_req     = 1'b0;
	int          min_level    = 3000;
	int          thr_level    = 10;
	int unsigned cycle_count  = 0;

	cell_balance_duty_controller uut (.*);

	cbd_checker u_checker (.*);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("cell_balance_duty_controller regression: fail");
			$finish;
		end
	end

	// receiver: calm, light and bursty stretches, plus one long hold-off on request
	initial begin
		int kind;
		int seg_len;
		int burst_left;
		burst_left = 0;
		forever begin
			kind    = $urandom_range(0, 9);
			seg_len = $urandom_range(5, 80);
			repeat (seg_len) begin
				@(posedge clk);
				if (hold_req) begin
					hold_req = 1'b0;
					out_stall <= 1'b1;
					repeat (LONG_HOLD) @(posedge clk);
				end else if (burst_left > 0) begin
					out_stall <= 1'b1;
					burst_left--;
				end else if (kind >= 8 && $urandom_range(0, 15) == 0) begin
					burst_left = $urandom_range(10, 40);
					out_stall <= 1'b1;
				end else if (kind < 4) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
			end
		end
	end

	// sender gap: mostly none, some short, a few long
	function automatic int next_gap();
		int r;
		if (tight_items > 0 || calm_sender)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one input transaction and hold it until accepted
	task automatic send_item(input mode_t md, input logic [CMD_W-1:0] cmd,
			input logic [CELL_ADDR_W-1:0] idx, input logic [VOLT_W-1:0] volt,
			input logic flt);
		int gap;
		bit taken;
		gap = next_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= md;
		command_value <= cmd;
		cell_index    <= idx;
		voltage_mv    <= volt;
		fault         <= flt;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		items_sent++;
		if (tight_items > 0)
			tight_items--;
	endtask

	// stop offering and wait until every predicted result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_count != 0);
		@(posedge clk);
	endtask

	// write all four registers back to back while idle
	task automatic program_regs(input logic [CFG_DATA_W-1:0] timeout_ms,
			input logic [CFG_DATA_W-1:0] rest_ms, input logic [CFG_DATA_W-1:0] active_ms,
			input logic [CFG_DATA_W-1:0] thr);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TIMEOUT;
		cfg_data  <= timeout_ms;
		@(posedge clk);
		cfg_index <= CFG_REST;
		cfg_data  <= rest_ms;
		@(posedge clk);
		cfg_index <= CFG_ACTIVE;
		cfg_data  <= active_ms;
		@(posedge clk);
		cfg_index <= CFG_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_level = thr[VOLT_W-1:0];
	endtask

	// voltage around the point where a cell starts to be selected
	function automatic logic [VOLT_W-1:0] near_voltage();
		int v;
		if ($urandom_range(0, 7) == 0)
			return VOLT_W'($urandom);
		v = min_level + ((thr_level < 1000) ? thr_level : 0) + int'($urandom_range(0, 40)) - 20;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return VOLT_W'(v);
	endfunction

	// well-formed run: load some voltages, enable, then a string of ticks and refreshes
	task automatic balance_sequence();
		int n_writes;
		int n_ticks;
		int pick;
		n_writes = $urandom_range(0, 3);
		repeat (n_writes) begin
			if ($urandom_range(0, 3) == 0) begin
				min_level = $urandom_range(3200, 3400);
				send_item(MODE_MIN_WR, CMD_W'($urandom), CELL_ADDR_W'($urandom),
					VOLT_W'(min_level), 1'($urandom));
			end else begin
				send_item(MODE_VOLT_WR, CMD_W'($urandom), CELL_ADDR_W'($urandom),
					near_voltage(), 1'($urandom));
			end
		end
		send_item(MODE_COMMAND, CMD_ENABLE, CELL_ADDR_W'($urandom), VOLT_W'($urandom),
			($urandom_range(0, 9) == 0));
		n_ticks = $urandom_range(1, 10);
		repeat (n_ticks) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				send_item(MODE_COMMAND, CMD_DISABLE, CELL_ADDR_W'($urandom),
					VOLT_W'($urandom), 1'($urandom));
			else if (pick == 1)
				send_item(MODE_COMMAND, CMD_W'($urandom_range(2, 255)),
					CELL_ADDR_W'($urandom), VOLT_W'($urandom), 1'($urandom));
			else if (pick == 2)
				send_item(MODE_COMMAND, CMD_ENABLE, CELL_ADDR_W'($urandom),
					VOLT_W'($urandom), ($urandom_range(0, 9) == 0));
			else
				send_item(MODE_TICK, CMD_W'($urandom), CELL_ADDR_W'($urandom),
					VOLT_W'($urandom), ($urandom_range(0, 14) == 0));
		end
	endtask

	// main stimulus
	initial begin
		logic [CFG_DATA_W-1:0] t_ms;
		logic [CFG_DATA_W-1:0] r_ms;
		logic [CFG_DATA_W-1:0] a_ms;
		logic [CFG_DATA_W-1:0] th;
		int phase_start;
		int pick;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset configuration: store extremes, threshold edge, commands
		send_item(MODE_VOLT_WR, '0, 7'd0, 16'hFFFF, 1'b1);
		send_item(MODE_VOLT_WR, '0, 7'd127, 16'h0000, 1'b0);
		send_item(MODE_VOLT_WR, '0, 7'd17, 16'd3000, 1'b0);
		send_item(MODE_VOLT_WR, '0, 7'd18, 16'd3010, 1'b0);
		send_item(MODE_VOLT_WR, '0, 7'd19, 16'd3011, 1'b0);
		send_item(MODE_VOLT_WR, '0, 7'd33, 16'd2000, 1'b0);
		send_item(MODE_MIN_WR, '0, '0, 16'd3000, 1'b1);
		send_item(MODE_COMMAND, CMD_ENABLE, '0, '0, 1'b1);
		send_item(MODE_TICK, '0, '0, '0, 1'b0);
		send_item(MODE_COMMAND, 8'hFF, '0, '0, 1'b0);
		send_item(MODE_COMMAND, CMD_ENABLE, '0, '0, 1'b0);
		send_item(MODE_TICK, '0, '0, '0, 1'b0);
		send_item(MODE_COMMAND, 8'hFE, '0, '0, 1'b0);
		send_item(MODE_COMMAND, CMD_DISABLE, '0, '0, 1'b0);
		send_item(MODE_TICK, '0, '0, '0, 1'b0);
		send_item(MODE_TICK, '0, '0, '0, 1'b1);
		send_item(MODE_COMMAND, CMD_ENABLE, '0, '0, 1'b0);
		send_item(MODE_TICK, '0, '0, '0, 1'b0);
		send_item(MODE_TICK, '0, '0, '0, 1'b1);
		drain_results();

		// largest threshold: minimum plus threshold runs past 16 bits, nothing selected
		program_regs(24'd1000, 24'd10000, 24'd30000, 24'hFFFFFF);
		send_item(MODE_MIN_WR, '0, '0, 16'd1, 1'b0);
		send_item(MODE_COMMAND, CMD_ENABLE, '0, '0, 1'b0);
		send_item(MODE_TICK, '0, '0, '0, 1'b0);
		drain_results();

		// random phases, each with its own register setting
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					t_ms = 24'($urandom_range(10, 40));
					r_ms = 24'($urandom_range(1, 5));
					a_ms = 24'($urandom_range(1, 5));
					th   = 24'($urandom_range(5, 50));
				end
				1: begin
					t_ms = '0;
					r_ms = '0;
					a_ms = '0;
					th   = '0;
				end
				2: begin
					t_ms = '1;
					r_ms = '1;
					a_ms = '1;
					th   = '1;
				end
				3: begin
					t_ms = 24'($urandom_range(1000, 100000));
					r_ms = '0;
					a_ms = '0;
					th   = 24'($urandom);
				end
				4: begin
					t_ms = 24'($urandom_range(3, 12));
					r_ms = 24'($urandom_range(0, 3));
					a_ms = 24'($urandom_range(0, 3));
					th   = 24'($urandom_range(0, 20));
				end
				default: begin
					t_ms = 24'($urandom);
					r_ms = 24'($urandom_range(0, 8));
					a_ms = 24'($urandom_range(0, 8));
					th   = 24'($urandom);
				end
			endcase
			program_regs(t_ms, r_ms, a_ms, th);
			calm_sender = (p == 3);
			// long receiver hold-off while the sender keeps offering back to back
			if (p == 0) begin
				hold_req    = 1'b1;
				tight_items = 30;
			end
			phase_start = items_sent;
			while (items_sent - phase_start < 52) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					balance_sequence();
				end else if (pick == 7) begin
					send_item(MODE_COMMAND, CMD_DISABLE, CELL_ADDR_W'($urandom),
						VOLT_W'($urandom), 1'($urandom));
					send_item(MODE_TICK, CMD_W'($urandom), CELL_ADDR_W'($urandom),
						VOLT_W'($urandom), 1'b0);
				end else begin
					send_item(mode_t'(MODE_W'($urandom)), CMD_W'($urandom),
						CELL_ADDR_W'($urandom), VOLT_W'($urandom), 1'($urandom));
				end
				if ($urandom_range(0, 29) == 0)
					drain_results();
			end
			drain_results();
		end

		// settle for one full mask walk, then check for leftovers
		repeat (200) @(posedge clk);
		run_done <= 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("cell_balance_duty_controller regression: pass");
		else
			$display("cell_balance_duty_controller regression: fail");
		$finish;
	end

endmodule
